// ===== sv/cab_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cab_pkg: shared types and constants of the clipped alpha blitter
// Holds the command and status words between controller and datapath, the
// configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package cab_pkg;

    // Fixed field widths.
    localparam int BYTE_W    = 8;
    localparam int LANE_W    = 3;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SRC_ORIGIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DST_ORIGIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COPY_EXTENT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_GEOMETRY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_GEOMETRY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SIZES   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_CONTROL = 3'd6;

    // Reset values of the registers that do not reset to zero.
    localparam logic [5:0] PIXEL_SIZES_RST   = 6'd36;
    localparam logic [8:0] BLEND_CONTROL_RST = 9'd255;

    // Full-scale alpha.
    localparam logic [BYTE_W-1:0] ALPHA_MAX = 8'd255;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clip_start;   // clamp starts, find clipped ends
        logic clip_size;    // derive column and row counts, empty flag
        logic row_mult;     // multiply start rows by pitches
        logic load_base;    // load start addresses, clear counters
        logic take;         // latch the input word
        logic blend_mult;   // register the two blend products
        logic emit;         // load the output register, advance the walk
    } cab_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;     // output register can take a word this cycle
    } cab_sts_t;

endpackage

`default_nettype wire

// ===== sv/cab_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cab_ctrl: sequencing controller of the clipped alpha blitter
// Runs the four-step plan computation after reset and after every register
// write, then steps each accepted word through take, multiply and emit.
// ----------------------------------------------------------------------------
module cab_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic              in_valid,
    input  wire cab_pkg::cab_sts_t sts,
    output cab_pkg::cab_cmd_t      cmd,
    output logic                   in_ready
);
    import cab_pkg::*;

    localparam logic [2:0] ST_CLIP_START = 3'd0;
    localparam logic [2:0] ST_CLIP_SIZE  = 3'd1;
    localparam logic [2:0] ST_ROW_MULT   = 3'd2;
    localparam logic [2:0] ST_LOAD_BASE  = 3'd3;
    localparam logic [2:0] ST_IDLE       = 3'd4;
    localparam logic [2:0] ST_BLEND      = 3'd5;
    localparam logic [2:0] ST_EMIT       = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register; reset starts with a plan computation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLIP_START;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_CLIP_START:
            begin
                cmd.clip_start = 1'b1;
                state_next     = ST_CLIP_SIZE;
            end
            ST_CLIP_SIZE:
            begin
                cmd.clip_size = 1'b1;
                state_next    = ST_ROW_MULT;
            end
            ST_ROW_MULT:
            begin
                cmd.row_mult = 1'b1;
                state_next   = ST_LOAD_BASE;
            end
            ST_LOAD_BASE:
            begin
                cmd.load_base = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                cmd.blend_mult = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLIP_START;
            end
        endcase

        // A register write always restarts the plan computation.
        if (cfg_write)
        begin
            state_next = ST_CLIP_START;
        end
    end

endmodule

`default_nettype wire

// ===== sv/cab_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cab_dp: datapath of the clipped alpha blitter
// Holds the configuration registers, the clipped plan, the walk counters and
// running addresses, the blend multipliers and the output register.
// ----------------------------------------------------------------------------
module cab_dp
#(
    parameter int COORD_WIDTH         = 16,
    parameter int ADDR_WIDTH          = 32,
    parameter int MAX_BYTES_PER_PIXEL = 4
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [cab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [3*COORD_WIDTH-1:0]       cfg_data,
    input  wire logic [cab_pkg::BYTE_W-1:0]     in_src_byte,
    input  wire logic [cab_pkg::BYTE_W-1:0]     in_dst_byte,
    input  wire cab_pkg::cab_cmd_t              cmd,
    output cab_pkg::cab_sts_t                   sts,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic [ADDR_WIDTH-1:0]               out_src_addr,
    output logic [ADDR_WIDTH-1:0]               out_dst_addr,
    output logic [cab_pkg::BYTE_W-1:0]          out_pixel_value,
    output logic                                out_write_enable,
    output logic                                out_last
);
    import cab_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int SW = COORD_WIDTH + 2;
    localparam int PW = 2 * COORD_WIDTH + 4;
    localparam int FW = (ADDR_WIDTH > PW) ? ADDR_WIDTH : PW;
    localparam logic [LANE_W-1:0] BPP_MAX = LANE_W'(MAX_BYTES_PER_PIXEL);

    // Configuration registers.
    logic [2*CW-1:0] src_origin_reg;
    logic [2*CW-1:0] dst_origin_reg;
    logic [2*CW-1:0] copy_extent_reg;
    logic [3*CW-1:0] src_geom_reg;
    logic [3*CW-1:0] dst_geom_reg;
    logic [5:0]      pixel_sizes_reg;
    logic [8:0]      blend_ctrl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_origin_reg  <= '0;
            dst_origin_reg  <= '0;
            copy_extent_reg <= '0;
            src_geom_reg    <= '0;
            dst_geom_reg    <= '0;
            pixel_sizes_reg <= PIXEL_SIZES_RST;
            blend_ctrl_reg  <= BLEND_CONTROL_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SRC_ORIGIN:    src_origin_reg  <= cfg_data[2*CW-1:0];
                REG_DST_ORIGIN:    dst_origin_reg  <= cfg_data[2*CW-1:0];
                REG_COPY_EXTENT:   copy_extent_reg <= cfg_data[2*CW-1:0];
                REG_SRC_GEOMETRY:  src_geom_reg    <= cfg_data;
                REG_DST_GEOMETRY:  dst_geom_reg    <= cfg_data;
                REG_PIXEL_SIZES:   pixel_sizes_reg <= cfg_data[5:0];
                REG_BLEND_CONTROL: blend_ctrl_reg  <= cfg_data[8:0];
                default:           ;
            endcase
        end
    end

    // Field views of the registers, widened to signed working width.
    logic signed [SW-1:0] sxo, syo, dxo, dyo, w_s, h_s;
    logic signed [SW-1:0] sbw, sbh, dbw, dbh;
    logic [CW-1:0]        spitch, dpitch;
    logic [LANE_W-1:0]    sbpp_raw, dbpp_raw, sbpp_sat, dbpp_sat, bpp_min;
    logic [BYTE_W-1:0]    alpha;

    always_comb
    begin
        sxo = {{2{src_origin_reg[CW-1]}},   src_origin_reg[CW-1:0]};
        syo = {{2{src_origin_reg[2*CW-1]}}, src_origin_reg[2*CW-1:CW]};
        dxo = {{2{dst_origin_reg[CW-1]}},   dst_origin_reg[CW-1:0]};
        dyo = {{2{dst_origin_reg[2*CW-1]}}, dst_origin_reg[2*CW-1:CW]};
        w_s = {2'b00, copy_extent_reg[CW-1:0]};
        h_s = {2'b00, copy_extent_reg[2*CW-1:CW]};
        sbw = {2'b00, src_geom_reg[CW-1:0]};
        sbh = {2'b00, src_geom_reg[2*CW-1:CW]};
        dbw = {2'b00, dst_geom_reg[CW-1:0]};
        dbh = {2'b00, dst_geom_reg[2*CW-1:CW]};
        spitch   = src_geom_reg[3*CW-1:2*CW];
        dpitch   = dst_geom_reg[3*CW-1:2*CW];
        sbpp_raw = pixel_sizes_reg[2:0];
        dbpp_raw = pixel_sizes_reg[5:3];
        sbpp_sat = (sbpp_raw > BPP_MAX) ? BPP_MAX : sbpp_raw;
        dbpp_sat = (dbpp_raw > BPP_MAX) ? BPP_MAX : dbpp_raw;
        bpp_min  = (sbpp_sat < dbpp_sat) ? sbpp_sat : dbpp_sat;
        alpha    = blend_ctrl_reg[7:0];
    end

    // Plan, first step: clamped starts, clipped ends, early empty checks.
    logic [CW-1:0]        sx_reg, sy_reg, dx_reg, dy_reg;
    logic signed [SW-1:0] s_end_x_reg, s_end_y_reg, d_end_x_reg, d_end_y_reg;
    logic                 reject_reg;
    logic [LANE_W-1:0]    sbpp_reg, dbpp_reg, bpp_reg;
    logic signed [SW-1:0] s_sum_x, s_sum_y, d_sum_x, d_sum_y;

    always_comb
    begin
        s_sum_x = sxo + w_s;
        s_sum_y = syo + h_s;
        d_sum_x = dxo + w_s;
        d_sum_y = dyo + h_s;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clip_start)
        begin
            sx_reg <= sxo[SW-1] ? '0 : sxo[CW-1:0];
            sy_reg <= syo[SW-1] ? '0 : syo[CW-1:0];
            dx_reg <= dxo[SW-1] ? '0 : dxo[CW-1:0];
            dy_reg <= dyo[SW-1] ? '0 : dyo[CW-1:0];
            s_end_x_reg <= (s_sum_x < sbw) ? s_sum_x : sbw;
            s_end_y_reg <= (s_sum_y < sbh) ? s_sum_y : sbh;
            d_end_x_reg <= (d_sum_x < dbw) ? d_sum_x : dbw;
            d_end_y_reg <= (d_sum_y < dbh) ? d_sum_y : dbh;
            reject_reg  <= (alpha == '0) || (bpp_min == '0) ||
                           (sxo > sbw) || (syo > sbh) || (dxo > dbw) || (dyo > dbh);
            sbpp_reg <= sbpp_sat;
            dbpp_reg <= dbpp_sat;
            bpp_reg  <= bpp_min;
        end
    end

    // Plan, second step: overlap counts and the empty flag.
    logic signed [SW-1:0] sx_s, sy_s, dx_s, dy_s;
    logic signed [SW-1:0] s_cols, d_cols, s_rows, d_rows, cols_s, rows_s;
    logic [CW-1:0]        cols_reg, rows_reg;
    logic                 empty_reg;

    always_comb
    begin
        sx_s   = {2'b00, sx_reg};
        sy_s   = {2'b00, sy_reg};
        dx_s   = {2'b00, dx_reg};
        dy_s   = {2'b00, dy_reg};
        s_cols = s_end_x_reg - sx_s;
        d_cols = d_end_x_reg - dx_s;
        s_rows = s_end_y_reg - sy_s;
        d_rows = d_end_y_reg - dy_s;
        cols_s = (d_cols < s_cols) ? d_cols : s_cols;
        rows_s = (d_rows < s_rows) ? d_rows : s_rows;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg <= 1'b1;
        end
        else if (cmd.clip_size)
        begin
            empty_reg <= reject_reg || (cols_s <= 0) || (rows_s <= 0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clip_size)
        begin
            cols_reg <= cols_s[CW-1:0];
            rows_reg <= rows_s[CW-1:0];
        end
    end

    // Plan, third step: start row times pitch.
    logic [2*CW-1:0] sy_prod_reg, dy_prod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.row_mult)
        begin
            sy_prod_reg <= sy_reg * spitch;
            dy_prod_reg <= dy_reg * dpitch;
        end
    end

    // Plan, fourth step: start addresses and row strides in bytes.
    logic [FW-1:0] src_lin, dst_lin, src_step_lin, dst_step_lin;

    always_comb
    begin
        src_lin = (FW'(sy_prod_reg) + FW'(sx_reg)) * FW'(sbpp_reg);
        dst_lin = (FW'(dy_prod_reg) + FW'(dx_reg)) * FW'(dbpp_reg);
        src_step_lin = FW'(spitch) * FW'(sbpp_reg);
        dst_step_lin = FW'(dpitch) * FW'(dbpp_reg);
    end

    logic [ADDR_WIDTH-1:0] src_base_reg, dst_base_reg;
    logic [ADDR_WIDTH-1:0] src_rstep_reg, dst_rstep_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_base)
        begin
            src_base_reg  <= src_lin[ADDR_WIDTH-1:0];
            dst_base_reg  <= dst_lin[ADDR_WIDTH-1:0];
            src_rstep_reg <= src_step_lin[ADDR_WIDTH-1:0];
            dst_rstep_reg <= dst_step_lin[ADDR_WIDTH-1:0];
        end
    end

    // Input word and blend products.
    logic [BYTE_W-1:0]   src_byte_reg, dst_byte_reg;
    logic [2*BYTE_W+1:0] src_prod_reg;
    logic [2*BYTE_W:0]   dst_prod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            src_byte_reg <= in_src_byte;
            dst_byte_reg <= in_dst_byte;
        end
        if (cmd.blend_mult)
        begin
            src_prod_reg <= ({1'b0, src_byte_reg} + 9'd1) * ({1'b0, alpha} + 9'd1);
            dst_prod_reg <= ({1'b0, dst_byte_reg} + 9'd1) * (ALPHA_MAX - alpha);
        end
    end

    // Output byte: sum of the products over 256, less one, when control bit 8 is set, else the source byte.
    logic [2*BYTE_W+1:0] blend_sum;
    logic [BYTE_W+1:0]   blend_hi;
    logic [BYTE_W-1:0]   pixel_val;

    always_comb
    begin
        blend_sum = src_prod_reg + {1'b0, dst_prod_reg};
        blend_hi  = blend_sum[2*BYTE_W+1:BYTE_W] - 10'd1;
        pixel_val = blend_ctrl_reg[8] ? blend_hi[BYTE_W-1:0] : src_byte_reg;
    end

    // Walk position: byte lane, column, row and running addresses.
    logic [LANE_W-1:0]     lane_reg, lane_next;
    logic [CW-1:0]         col_reg, col_next, row_reg, row_next;
    logic [ADDR_WIDTH-1:0] src_pix_reg, src_pix_next, src_row_reg, src_row_next;
    logic [ADDR_WIDTH-1:0] dst_pix_reg, dst_pix_next, dst_row_reg, dst_row_next;
    logic                  lane_last, col_last, row_last, fin;

    always_comb
    begin
        lane_last = (lane_reg == bpp_reg - LANE_W'(1));
        col_last  = (col_reg == cols_reg - CW'(1));
        row_last  = (row_reg == rows_reg - CW'(1));
        fin       = lane_last && col_last && row_last;

        lane_next    = lane_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        src_pix_next = src_pix_reg;
        src_row_next = src_row_reg;
        dst_pix_next = dst_pix_reg;
        dst_row_next = dst_row_reg;

        if (cmd.load_base)
        begin
            lane_next    = '0;
            col_next     = '0;
            row_next     = '0;
            src_pix_next = src_lin[ADDR_WIDTH-1:0];
            src_row_next = src_lin[ADDR_WIDTH-1:0];
            dst_pix_next = dst_lin[ADDR_WIDTH-1:0];
            dst_row_next = dst_lin[ADDR_WIDTH-1:0];
        end
        else if (cmd.emit && !empty_reg)
        begin
            if (fin)
            begin
                // Blit done: the next word starts it over.
                lane_next    = '0;
                col_next     = '0;
                row_next     = '0;
                src_pix_next = src_base_reg;
                src_row_next = src_base_reg;
                dst_pix_next = dst_base_reg;
                dst_row_next = dst_base_reg;
            end
            else if (!lane_last)
            begin
                lane_next = lane_reg + LANE_W'(1);
            end
            else if (!col_last)
            begin
                lane_next    = '0;
                col_next     = col_reg + CW'(1);
                src_pix_next = src_pix_reg + ADDR_WIDTH'(sbpp_reg);
                dst_pix_next = dst_pix_reg + ADDR_WIDTH'(dbpp_reg);
            end
            else
            begin
                lane_next    = '0;
                col_next     = '0;
                row_next     = row_reg + CW'(1);
                src_row_next = src_row_reg + src_rstep_reg;
                src_pix_next = src_row_reg + src_rstep_reg;
                dst_row_next = dst_row_reg + dst_rstep_reg;
                dst_pix_next = dst_row_reg + dst_rstep_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            lane_reg <= lane_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_pix_reg <= src_pix_next;
        src_row_reg <= src_row_next;
        dst_pix_reg <= dst_pix_next;
        dst_row_reg <= dst_row_next;
    end

    // Output register.
    logic                  out_valid_reg;
    logic [ADDR_WIDTH-1:0] out_src_reg, out_dst_reg;
    logic [BYTE_W-1:0]     out_pix_reg;
    logic                  out_we_reg, out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (empty_reg)
            begin
                out_src_reg  <= '0;
                out_dst_reg  <= '0;
                out_pix_reg  <= '0;
                out_we_reg   <= 1'b0;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_src_reg  <= src_pix_reg + ADDR_WIDTH'(lane_reg);
                out_dst_reg  <= dst_pix_reg + ADDR_WIDTH'(lane_reg);
                out_pix_reg  <= pixel_val;
                out_we_reg   <= 1'b1;
                out_last_reg <= fin;
            end
        end
    end

    always_comb
    begin
        sts.out_free     = !out_valid_reg || out_ready;
        out_valid        = out_valid_reg;
        out_src_addr     = out_src_reg;
        out_dst_addr     = out_dst_reg;
        out_pixel_value  = out_pix_reg;
        out_write_enable = out_we_reg;
        out_last         = out_last_reg;
    end

endmodule

`default_nettype wire

// ===== sv/clipped_alpha_blit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_alpha_blit: byte walker of an alpha-blending block transfer
// Walks the clipped rectangle byte by byte, giving source and destination
// byte addresses and the copied or blended byte for every input word.
// ----------------------------------------------------------------------------
// Each input word carries the source and destination bytes of the current
// position and yields one output word; a byte passes through accept, blend
// multiply and load of the output register, the last step waiting until the
// output register is free, in the controller's per-byte sequence around the
// registered blend multipliers, so a new word is accepted only after the last
// one is loaded. The output register lets the next word be accepted while a
// result still waits. After reset and after every register write the block
// computes the clipped plan (start clamp, overlap counts, row multiply,
// start addresses) before it accepts a word; writes restart the walk. An
// empty blit answers every word with write enable low and last high.
module clipped_alpha_blit
#(
    parameter int COORD_WIDTH         = 16,
    parameter int ADDR_WIDTH          = 32,
    parameter int MAX_BYTES_PER_PIXEL = 4
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration write channel.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cab_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [3*COORD_WIDTH-1:0]      cfg_data,
    // Input stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [2*cab_pkg::BYTE_W-1:0]  s_tdata,  // src_byte, dst_byte
    // Output stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [((2*ADDR_WIDTH+cab_pkg::BYTE_W+7)/8)*8-1:0] m_tdata,
                                               // src_addr, dst_addr, pixel_value
    output logic [0:0]                         m_tuser,  // write_enable
    output logic                               m_tlast
);
    import cab_pkg::*;

    localparam int OUT_DATA_W = ((2 * ADDR_WIDTH + BYTE_W + 7) / 8) * 8;

    cab_cmd_t              cmd;
    cab_sts_t              sts;
    logic [ADDR_WIDTH-1:0] src_addr, dst_addr;
    logic [BYTE_W-1:0]     pixel_value;
    logic                  write_enable;
    logic                  cfg_write;

    // Registers are always writable.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;

    cab_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .in_valid  (s_tvalid),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (s_tready)
    );

    cab_dp
    #(
        .COORD_WIDTH         (COORD_WIDTH),
        .ADDR_WIDTH          (ADDR_WIDTH),
        .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_src_byte      (s_tdata[BYTE_W-1:0]),
        .in_dst_byte      (s_tdata[2*BYTE_W-1:BYTE_W]),
        .cmd              (cmd),
        .sts              (sts),
        .out_ready        (m_tready),
        .out_valid        (m_tvalid),
        .out_src_addr     (src_addr),
        .out_dst_addr     (dst_addr),
        .out_pixel_value  (pixel_value),
        .out_write_enable (write_enable),
        .out_last         (m_tlast)
    );

    // Pack the output word, first field lowest, zero fill to whole bytes.
    assign m_tdata    = OUT_DATA_W'({pixel_value, dst_addr, src_addr});
    assign m_tuser[0] = write_enable;

endmodule

`default_nettype wire
